[src/gwwb_pkg.sv]
// Package for the gray-world white balance unit: widths, actions and the
// front-to-back command word. No dependencies.
package gwwb_pkg;
    localparam int MaxPixelsLog2Def = 24;
    localparam int SampleW          = 8;
    localparam int SumW             = 32;
    localparam int QueueDepth       = 2;

    typedef enum logic {
        ACT_MEASURE = 1'b0,
        ACT_CORRECT = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CMD_CORRECT = 2'd0,
        CMD_LATCH   = 2'd1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [SampleW-1:0] blue;
        logic [SampleW-1:0] green;
        logic [SampleW-1:0] red;
        logic [SumW-1:0]    blue_sum;
        logic [SumW-1:0]    green_sum;
        logic [SumW-1:0]    red_sum;
        logic [SumW-1:0]    count;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV   = 2'd1,
        ST_OUT   = 2'd2
    } t_back_state;
endpackage

[src/gwwb_front.sv]
// Front part: accumulates measure pixels into sums and the count, and turns
// correct pixels and frame ends into commands. Depends on gwwb_pkg.
module gwwb_front #(
    parameter int MAX_PIXELS_LOG2 = gwwb_pkg::MaxPixelsLog2Def
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_action,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_red,
    input  logic          i_frame_end,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output gwwb_pkg::t_cmd o_cmd
);
    localparam int CntW = MAX_PIXELS_LOG2 + 1;
    localparam logic [CntW-1:0] Limit = CntW'(1) << MAX_PIXELS_LOG2;

    logic [gwwb_pkg::SumW-1:0] r_bsum, r_gsum, r_rsum, n_bsum, n_gsum, n_rsum;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            w_take, w_corr, w_room;

    assign w_corr = (i_action == gwwb_pkg::ACT_CORRECT);
    // correct and latching measure items need a queue slot
    assign o_cmd_valid = i_valid && (w_corr || i_frame_end);
    assign o_ready = i_cmd_ready || !(w_corr || i_frame_end);
    assign w_take = i_valid && o_ready;
    assign w_room = (r_cnt < Limit);

    always_comb begin
        n_bsum = r_bsum + (w_room ? {24'd0, i_blue}  : '0);
        n_gsum = r_gsum + (w_room ? {24'd0, i_green} : '0);
        n_rsum = r_rsum + (w_room ? {24'd0, i_red}   : '0);
        n_cnt  = r_cnt + (w_room ? CntW'(1) : '0);
        o_cmd.kind      = w_corr ? gwwb_pkg::CMD_CORRECT : gwwb_pkg::CMD_LATCH;
        o_cmd.blue      = i_blue;
        o_cmd.green     = i_green;
        o_cmd.red       = i_red;
        o_cmd.blue_sum  = n_bsum;
        o_cmd.green_sum = n_gsum;
        o_cmd.red_sum   = n_rsum;
        o_cmd.count     = gwwb_pkg::SumW'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsum <= '0;
            r_gsum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
        end else if (w_take && !w_corr) begin
            if (i_frame_end) begin
                r_bsum <= '0;
                r_gsum <= '0;
                r_rsum <= '0;
                r_cnt  <= '0;
            end else begin
                r_bsum <= n_bsum;
                r_gsum <= n_gsum;
                r_rsum <= n_rsum;
                r_cnt  <= n_cnt;
            end
        end
    end
endmodule

[src/gwwb_queue.sv]
// Short command queue between front and back parts. Depends on gwwb_pkg.
module gwwb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gwwb_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output gwwb_pkg::t_cmd o_data
);
    gwwb_pkg::t_cmd r_mem [gwwb_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[src/gwwb_back.sv]
// Back part: serial restoring divider shared by the three channels; latches
// averages on frame-end commands and balances correct commands. Depends on gwwb_pkg.
module gwwb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  gwwb_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_green,
    output logic [7:0]     o_red
);
    localparam int W = gwwb_pkg::SumW;

    gwwb_pkg::t_back_state r_st, n_st;
    gwwb_pkg::t_cmd_kind   r_kind;
    logic [1:0]   r_ch;
    logic [5:0]   r_bit;
    logic [W-1:0] r_num [3];
    logic [W-1:0] r_den [3];
    logic [W-1:0] r_quo, r_rem;
    logic [W:0]   w_trial;
    logic [W-1:0] w_rem_sh;
    logic [7:0]   r_avg [3];
    logic [7:0]   r_res [3];
    logic [7:0]   w_fin;
    logic         w_last_bit, w_start, w_fire;

    assign w_rem_sh = {r_rem[W-2:0], r_num[r_ch][5'(r_bit)]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_den[r_ch]};
    assign w_last_bit = (r_bit == 6'd0);

    // final value of the channel just divided
    always_comb begin
        logic [W-1:0] q;
        q = {r_quo[W-2:0], ~w_trial[W]};
        if (r_den[r_ch] == '0) w_fin = (r_num[r_ch] != '0) ? 8'd255 : 8'd0;
        else w_fin = (q > W'(255)) ? 8'd255 : q[7:0];
    end

    assign o_cmd_ready = (r_st == gwwb_pkg::ST_IDLE);
    assign w_start = i_cmd_valid && o_cmd_ready;
    assign w_fire  = (r_st == gwwb_pkg::ST_DIV) && w_last_bit && (r_ch == 2'd2);

    always_comb begin
        n_st = r_st;
        case (r_st)
            gwwb_pkg::ST_IDLE: if (w_start) n_st = gwwb_pkg::ST_DIV;
            gwwb_pkg::ST_DIV:
                if (w_fire) n_st = (r_kind == gwwb_pkg::CMD_CORRECT) ?
                                   gwwb_pkg::ST_OUT : gwwb_pkg::ST_IDLE;
            gwwb_pkg::ST_OUT: if (i_ready) n_st = gwwb_pkg::ST_IDLE;
            default: n_st = gwwb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid = (r_st == gwwb_pkg::ST_OUT);
        o_blue  = r_res[0];
        o_green = r_res[1];
        o_red   = r_res[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= gwwb_pkg::ST_IDLE;
            r_avg[0] <= '0;
            r_avg[1] <= '0;
            r_avg[2] <= '0;
        end else begin
            r_st <= n_st;
            if (w_fire && r_kind == gwwb_pkg::CMD_LATCH) begin
                r_avg[0] <= r_res[0];
                r_avg[1] <= r_res[1];
                r_avg[2] <= w_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_kind <= i_cmd.kind;
            r_ch <= 2'd0;
            r_quo <= '0;
            r_rem <= '0;
            if (i_cmd.kind == gwwb_pkg::CMD_CORRECT) begin
                r_bit <= 6'd15;
                r_num[0] <= {17'd0, i_cmd.blue,  7'd0};
                r_num[1] <= {17'd0, i_cmd.green, 7'd0};
                r_num[2] <= {17'd0, i_cmd.red,   7'd0};
                r_den[0] <= {24'd0, r_avg[0]};
                r_den[1] <= {24'd0, r_avg[1]};
                r_den[2] <= {24'd0, r_avg[2]};
            end else begin
                r_bit <= 6'(W - 1);
                r_num[0] <= i_cmd.blue_sum;
                r_num[1] <= i_cmd.green_sum;
                r_num[2] <= i_cmd.red_sum;
                r_den[0] <= i_cmd.count;
                r_den[1] <= i_cmd.count;
                r_den[2] <= i_cmd.count;
            end
        end else if (r_st == gwwb_pkg::ST_DIV) begin
            if (w_last_bit) begin
                r_res[r_ch] <= w_fin;
                r_ch <= r_ch + 2'd1;
                r_quo <= '0;
                r_rem <= '0;
                r_bit <= (r_kind == gwwb_pkg::CMD_CORRECT) ? 6'd15 : 6'(W - 1);
            end else begin
                r_quo <= {r_quo[W-2:0], ~w_trial[W]};
                r_rem <= w_trial[W] ? w_rem_sh : w_trial[W-1:0];
                r_bit <= r_bit - 6'd1;
            end
        end
    end
endmodule

[src/gray_world_white_balance_unit.sv]
// Top level of the gray-world white balance unit: front accumulator, command
// queue and serial divider back end. Depends on gwwb_pkg and the gwwb_* modules.
//
//  channel | dir | fields (tdata low bit up)           | tuser
//  s_axis  | in  | blue, green, red, frame_end (32 b)  | action
//  m_axis  | out | blue_out, green_out, red_out (24 b) | -
//
// Measure pixels are always accepted and give no word. Correct pixels and frame
// ends each take their turn in the shared bit-serial divider, channel by channel.
// Reset clears sums, count and averages; a two-entry queue lets the front keep
// accumulating while the back end divides or waits on m_axis_tready.
module gray_world_white_balance_unit #(
    parameter int MAX_PIXELS_LOG2 = gwwb_pkg::MaxPixelsLog2Def
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // blue, green, red, frame_end, zero pad
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // blue_out, green_out, red_out
);
    logic           w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    gwwb_pkg::t_cmd w_fq_cmd, w_qb_cmd;

    gwwb_front #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_action(s_axis_tuser),
        .i_blue(s_axis_tdata[7:0]), .i_green(s_axis_tdata[15:8]),
        .i_red(s_axis_tdata[23:16]), .i_frame_end(s_axis_tdata[24]),
        .o_cmd_valid(w_fq_valid), .i_cmd_ready(w_fq_ready), .o_cmd(w_fq_cmd)
    );

    gwwb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fq_valid), .o_ready(w_fq_ready), .i_data(w_fq_cmd),
        .o_valid(w_qb_valid), .i_ready(w_qb_ready), .o_data(w_qb_cmd)
    );

    gwwb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_qb_valid), .o_cmd_ready(w_qb_ready), .i_cmd(w_qb_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_blue(m_axis_tdata[7:0]), .o_green(m_axis_tdata[15:8]),
        .o_red(m_axis_tdata[23:16])
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_qb_ready)
        else $error("back end took a command while a word is pending");
    a_measure_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tuser && !s_axis_tdata[24] |-> s_axis_tready)
        else $error("measure pixel stalled");
endmodule
